// ===== hw/rtl/krh_pkg.sv =====
package krh_pkg;

    localparam int BINS = 101;
    localparam logic [6:0] BIN_MAX = 7'd100;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_SEARCH,
        S_ADDR,
        S_RD,
        S_UPD,
        S_SAT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [23:0] meth_reads;
        logic [23:0] unmeth_reads;
        logic [63:0] context_key;
        logic [3:0]  read_context;
        logic [6:0]  read_bin;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  ctx_idx;
        logic [6:0]  bin;
        logic [63:0] stored_key;
        logic [39:0] bin_count;
        logic [63:0] meth_sum;
        logic [63:0] total_sum;
        logic [4:0]  contexts_used;
    } t_out;

endpackage

// ===== hw/rtl/krh_ram.sv =====
module krh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/keyed_ratio_histogram_top.sv =====
// Channel | Dir | Handshake            | Payload
// in      | in  | i_in_valid/o_in_ready | i_in  (t_in)
// out     | out | o_out_valid/i_out_ready | o_out (t_out)
//
// One item at a time. A record goes through the bit-serial bin division, the
// key search and a read-modify-write of the accumulator memory. A read goes
// straight to the memory read; a zero total or an unused read goes straight to
// the output. After reset a clearing pass zeroes all CONTEXTS*101 words of the
// memory, with the input held off. A finished item waits in the output
// register; stalls on the output hold the block.
module keyed_ratio_histogram_top
    import krh_pkg::*;
#(
    parameter int CONTEXTS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);
    localparam int DEPTH = CONTEXTS * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int MW    = 40 + 64 + 64;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_state r_state, n_state;
    t_in    r_item;
    t_out   r_out;
    logic   r_out_valid;

    logic [63:0] r_keys [CONTEXTS];
    logic [4:0]  r_used;

    // divider: (200*meth+total) / (2*total), restoring, one bit a cycle
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [25:0] r_den;
    logic [4:0]  r_dcnt;
    logic [24:0] w_total;
    logic [33:0] w_trial;

    logic [4:0]  r_sidx;
    logic        r_found;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_clr;
    logic [6:0]  r_bin;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [MW-1:0] w_wdata, w_rdata;
    logic [MW-1:0] r_new;

    logic [40:0] w_cnt_inc;
    logic [64:0] w_ms, w_ts;

    assign w_total = {1'b0, i_in.meth_reads} + {1'b0, i_in.unmeth_reads};
    assign w_trial = {r_rem, r_quo[31]} - {8'd0, r_den};

    krh_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_acc (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // accumulator update, saturating
    assign w_cnt_inc = {1'b0, w_rdata[MW-1 -: 40]} + 41'd1;
    assign w_ms = {1'b0, w_rdata[127:64]} + {41'd0, r_item.meth_reads};
    assign w_ts = {1'b0, w_rdata[63:0]}
                + {40'd0, {1'b0, r_item.meth_reads} + {1'b0, r_item.unmeth_reads}};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_new;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_SAT: w_we = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_in.operation == OP_READ) begin
                        if ({1'b0, i_in.read_context} >= r_used
                                || i_in.read_bin > BIN_MAX) n_state = S_OUT;
                        else                                n_state = S_RD;
                    end
                    else if (w_total == '0)        n_state = S_OUT;
                    else                           n_state = S_DIV;
                end
            end
            S_DIV:    if (r_dcnt == 5'd0) n_state = S_SEARCH;
            S_SEARCH: if (r_found || r_sidx >= r_used) n_state = S_ADDR;
            S_ADDR: begin
                // unknown key with a full table: dropped, no memory access
                if (!r_found && r_used >= 5'(CONTEXTS)) n_state = S_OUT;
                else                                   n_state = S_RD;
            end
            S_RD:     n_state = S_UPD;
            S_UPD: begin
                if (r_item.operation == OP_READ) n_state = S_OUT;
                else                             n_state = S_SAT;
            end
            S_SAT:    n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_clr       <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AW'(1);
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_item <= i_in;
                        r_out  <= '0;
                        r_out.contexts_used <= r_used;
                        if (i_in.operation == OP_READ) begin
                            r_out.ctx_idx <= i_in.read_context;
                            r_out.bin     <= i_in.read_bin;
                            if ({1'b0, i_in.read_context} >= r_used
                                    || i_in.read_bin > BIN_MAX) begin
                                r_out.status <= ST_UNUSED;
                            end else begin
                                r_out.status <= ST_OK;
                                r_out.stored_key <= r_keys[i_in.read_context[CW-1:0]];
                                r_addr  <= AW'(i_in.read_context[CW-1:0] * BINS)
                                         + AW'(i_in.read_bin);
                            end
                        end else if (w_total == '0) begin
                            r_out.status <= ST_ZERO;
                        end
                        // dividend 200*meth+total, 32 bits
                        r_quo  <= 32'(({8'd0, i_in.meth_reads} << 7)
                                    + ({8'd0, i_in.meth_reads} << 6)
                                    + ({8'd0, i_in.meth_reads} << 3)
                                    + {7'd0, w_total});
                        r_rem  <= '0;
                        r_den  <= {w_total, 1'b0};
                        r_dcnt <= 5'd31;
                        r_sidx <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_DIV: begin
                    // 200*meth+total < 2^32 since meth < 2^24 and total < 2^25
                    r_quo <= {r_quo[30:0], ~w_trial[33]};
                    r_rem <= w_trial[33] ? {r_rem[31:0], r_quo[31]} : w_trial[32:0];
                    r_dcnt <= r_dcnt - 5'd1;
                end
                S_SEARCH: begin
                    // quotient is stable for the whole search
                    r_bin <= (r_quo > 32'(BIN_MAX)) ? BIN_MAX : r_quo[6:0];
                    if (!r_found && r_sidx < r_used) begin
                        if (r_keys[r_sidx[CW-1:0]] == r_item.context_key)
                            r_found <= 1'b1;
                        else
                            r_sidx <= r_sidx + 5'd1;
                    end
                end
                S_ADDR: begin
                    if (!r_found && r_used >= 5'(CONTEXTS)) begin
                        r_out.status <= ST_FULL;
                        r_out.bin    <= r_bin;
                    end else begin
                        if (!r_found) begin
                            r_keys[r_sidx[CW-1:0]] <= r_item.context_key;
                            r_used <= r_used + 5'd1;
                            r_out.contexts_used <= r_used + 5'd1;
                        end
                        r_out.status     <= ST_OK;
                        r_out.ctx_idx    <= 4'(r_sidx);
                        r_out.bin        <= r_bin;
                        r_out.stored_key <= r_item.context_key;
                        r_addr <= AW'(r_sidx[CW-1:0] * BINS) + AW'(r_bin);
                    end
                end
                S_RD: ;
                S_UPD: begin
                    if (r_item.operation == OP_READ) begin
                        r_out.bin_count <= w_rdata[MW-1 -: 40];
                        r_out.meth_sum  <= w_rdata[127:64];
                        r_out.total_sum <= w_rdata[63:0];
                    end else begin
                        r_new[MW-1 -: 40] <= w_cnt_inc[40] ? '1 : w_cnt_inc[39:0];
                        r_new[127:64]     <= w_ms[64] ? '1 : w_ms[63:0];
                        r_new[63:0]       <= w_ts[64] ? '1 : w_ts[63:0];
                    end
                end
                S_SAT: begin
                    r_out.bin_count <= r_new[MW-1 -: 40];
                    r_out.meth_sum  <= r_new[127:64];
                    r_out.total_sum <= r_new[63:0];
                end
                S_OUT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// ===== verif/keyed_ratio_histogram_top_tb.sv =====
module keyed_ratio_histogram_top_tb;
    import krh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CTX    = 10;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 60;
    localparam int NUM_RANDOM = 1425;
    localparam logic [39:0] CNT_SAT = '1;
    localparam logic [63:0] SUM_SAT = '1;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    keyed_ratio_histogram_top #(.CONTEXTS(NUM_CTX)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the histogram: key table plus three accumulators per bin
    logic [63:0] shadow_keys [NUM_CTX];
    int          shadow_used;
    logic [39:0] shadow_count [NUM_CTX*BINS];
    logic [63:0] shadow_meth  [NUM_CTX*BINS];
    logic [63:0] shadow_total [NUM_CTX*BINS];

    t_out        expected_results [$];
    logic [63:0] known_keys [$];
    int          fail_count;
    int          cycle_count;
    bit          hold_req;
    int          send_burst;

    function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SUM_SAT : s[63:0];
    endfunction

    // Advances the shadow state by one item and returns the result it should give
    function automatic t_out predict_histogram(t_in it);
        t_out        r;
        logic [63:0] tot;
        logic [63:0] bin_q;
        int          idx;
        int          addr;
        bit          hit;
        r = '0;
        hit = 1'b0;
        if (it.operation == OP_READ) begin
            r.ctx_idx = it.read_context;
            r.bin = it.read_bin;
            if (int'(it.read_context) >= shadow_used || it.read_bin > BIN_MAX) begin
                r.status = ST_UNUSED;
            end else begin
                addr = int'(it.read_context) * BINS + int'(it.read_bin);
                r.status     = ST_OK;
                r.stored_key = shadow_keys[it.read_context];
                r.bin_count  = shadow_count[addr];
                r.meth_sum   = shadow_meth[addr];
                r.total_sum  = shadow_total[addr];
            end
            r.contexts_used = 5'(shadow_used);
            return r;
        end
        tot = 64'(it.meth_reads) + 64'(it.unmeth_reads);
        if (tot == 0) begin
            r.status = ST_ZERO;
            r.contexts_used = 5'(shadow_used);
            return r;
        end
        bin_q = (64'd200 * 64'(it.meth_reads) + tot) / (64'd2 * tot);
        if (bin_q > 100) bin_q = 100;
        idx = 0;
        for (int k = 0; k < shadow_used; k++) begin
            if (!hit && shadow_keys[k] == it.context_key) begin
                hit = 1'b1;
                idx = k;
            end
        end
        if (!hit) begin
            if (shadow_used >= NUM_CTX) begin
                r.status = ST_FULL;
                r.bin = bin_q[6:0];
                r.contexts_used = 5'(shadow_used);
                return r;
            end
            idx = shadow_used;
            shadow_keys[idx] = it.context_key;
            shadow_used++;
        end
        addr = idx * BINS + int'(bin_q);
        if (shadow_count[addr] != CNT_SAT) shadow_count[addr]++;
        shadow_meth[addr]  = add_sat64(shadow_meth[addr], 64'(it.meth_reads));
        shadow_total[addr] = add_sat64(shadow_total[addr], tot);
        r.status        = ST_OK;
        r.ctx_idx       = 4'(idx);
        r.bin           = bin_q[6:0];
        r.stored_key    = shadow_keys[idx];
        r.bin_count     = shadow_count[addr];
        r.meth_sum      = shadow_meth[addr];
        r.total_sum     = shadow_total[addr];
        r.contexts_used = 5'(shadow_used);
        return r;
    endfunction

    // Offer one item after a random gap; valid is only lowered when a gap follows,
    // so back-to-back items keep valid high with a single assignment per step.
    task automatic send_item(t_in it);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0) send_burst = 20;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_histogram(it));
    endtask

    function automatic t_in make_record(logic [23:0] m, logic [23:0] u, logic [63:0] key);
        t_in it;
        it = '0;
        it.operation    = OP_RECORD;
        it.meth_reads   = m;
        it.unmeth_reads = u;
        it.context_key  = key;
        it.read_context = 4'($urandom);
        it.read_bin     = 7'($urandom);
        return it;
    endfunction

    function automatic t_in make_read(logic [3:0] ctx, logic [6:0] b);
        t_in it;
        it = '0;
        it.operation    = OP_READ;
        it.meth_reads   = 24'($urandom);
        it.unmeth_reads = 24'($urandom);
        it.context_key  = {$urandom, $urandom};
        it.read_context = ctx;
        it.read_bin     = b;
        return it;
    endfunction

    function automatic logic [23:0] rand_reads();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    // Field extremes, rounding, an empty-table read and the zero-total and zero-key cases
    task automatic test_record_edges();
        send_item(make_record(24'd0, 24'd0, 64'h0000_0000_0047_4343));
        send_item(make_read(4'd0, 7'd0));      // empty table: index unused
        send_item(make_record(24'hFFFFFF, 24'd0, 64'h0000_0000_0047_4343));
        send_item(make_record(24'd0, 24'hFFFFFF, 64'h0000_0000_0047_4343));
        send_item(make_record(24'd1, 24'd1, 64'h0));             // exact half
        send_item(make_record(24'd1, 24'd199, 64'hFFFF_FFFF_FFFF_FFFF)); // 0.5% rounds up
        send_item(make_record(24'hFFFFFF, 24'hFFFFFF, 64'h0));
        known_keys.push_back(64'h0000_0000_0047_4343);
        known_keys.push_back(64'h0);
        known_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // Fill the key table with random keys, then hit it with unknown ones
    task automatic test_table_full();
        logic [63:0] key;
        while (known_keys.size() < NUM_CTX) begin
            key = {$urandom, $urandom};
            known_keys.push_back(key);
            send_item(make_record(rand_reads(), 24'($urandom_range(1, 1000)), key));
        end
        send_item(make_record(24'd3, 24'd1, {$urandom, $urandom}));
        send_item(make_record(24'd0, 24'd0, {$urandom, $urandom}));
    endtask

    task automatic test_reads();
        send_item(make_read(4'd0, 7'd100));
        send_item(make_read(4'd1, 7'd50));
        send_item(make_read(4'd9, 7'd0));
        send_item(make_read(4'd10, 7'd5));     // beyond the table
        send_item(make_read(4'd15, 7'd127));
        send_item(make_read(4'd2, 7'd101));    // bin out of range
    endtask

    // Mostly records on known keys so bins accumulate; reads mostly aim at
    // in-range contexts and bins. The output is held off once for a long stretch.
    task automatic test_random_traffic();
        t_in it;
        int  sel;
        hold_req = 1'b1;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 62) begin
                it = make_record(rand_reads(), rand_reads(),
                                 known_keys[$urandom_range(0, NUM_CTX - 1)]);
            end else if (sel < 68) begin
                it = make_record(rand_reads(), rand_reads(), {$urandom, $urandom});
            end else if (sel < 72) begin
                it = make_record(24'd0, 24'd0, {$urandom, $urandom});
            end else if (sel < 92) begin
                it = make_read(4'($urandom_range(0, NUM_CTX - 1)),
                               7'($urandom_range(0, 100)));
            end else begin
                it = make_read(4'($urandom), 7'($urandom));
            end
            send_item(it);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Output side: random stalls, zero-stall bursts, one long hold-off
    initial begin : out_side
        int w;
        int burst;
        burst = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            if (burst > 0) begin
                w = 0;
                burst--;
            end else begin
                w = $urandom_range(0, 12);
                if ($urandom_range(0, 15) == 0) burst = 20;
            end
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected item on output: %p", o_out);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_out.status);
                    fail_count++;
                end
                if (o_out.ctx_idx !== exp_r.ctx_idx) begin
                    $error("ctx_idx: expected %0d, got %0d",
                           exp_r.ctx_idx, o_out.ctx_idx);
                    fail_count++;
                end
                if (o_out.bin !== exp_r.bin) begin
                    $error("bin: expected %0d, got %0d", exp_r.bin, o_out.bin);
                    fail_count++;
                end
                if (o_out.stored_key !== exp_r.stored_key) begin
                    $error("stored_key: expected %h, got %h",
                           exp_r.stored_key, o_out.stored_key);
                    fail_count++;
                end
                if (o_out.bin_count !== exp_r.bin_count) begin
                    $error("bin_count: expected %0d, got %0d",
                           exp_r.bin_count, o_out.bin_count);
                    fail_count++;
                end
                if (o_out.meth_sum !== exp_r.meth_sum) begin
                    $error("meth_sum: expected %0d, got %0d", exp_r.meth_sum, o_out.meth_sum);
                    fail_count++;
                end
                if (o_out.total_sum !== exp_r.total_sum) begin
                    $error("total_sum: expected %0d, got %0d",
                           exp_r.total_sum, o_out.total_sum);
                    fail_count++;
                end
                if (o_out.contexts_used !== exp_r.contexts_used) begin
                    $error("contexts_used: expected %0d, got %0d",
                           exp_r.contexts_used, o_out.contexts_used);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog; the cap covers the clearing pass, the long hold-off and
    // every item at its worst gap, stall and processing time, several times over
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        hold_req    = 1'b0;
        send_burst  = 0;
        shadow_used = 0;
        foreach (shadow_keys[k]) shadow_keys[k] = '0;
        foreach (shadow_count[k]) begin
            shadow_count[k] = '0;
            shadow_meth[k]  = '0;
            shadow_total[k] = '0;
        end
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the input stays held off during the memory clear; send_item waits on ready
        test_record_edges();
        test_table_full();
        test_reads();
        test_random_traffic();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
